// ===== rtl/hbd_pkg.sv =====
package hbd_pkg;

  localparam int CODE_W = 32;  // received codeword width
  localparam int DATA_W = 26;  // extracted data width
  localparam int LEN_W  = 6;   // code_length register width
  localparam int SYN_W  = 6;   // syndrome only sums positions 1..32

  localparam logic [LEN_W-1:0] LEN_RESET = 6'd7;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [SYN_W-1:0] syn;
  } s1_ctl_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             bad;
  } s2_ctl_t;

  // Codeword position (from 1) that holds data bit idx; parity sits at powers of two.
  function automatic int data_pos(input int idx);
    int found;
    found    = 0;
    data_pos = 0;
    for (int p = 1; p < 128; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (found == idx && data_pos == 0) data_pos = p;
        found++;
      end
    end
  endfunction

endpackage

// ===== rtl/hbd_if.sv =====
interface hbd_in_if;
  logic                        valid;
  logic                        ready;
  logic [hbd_pkg::CODE_W-1:0]  code_word;

  modport source (output valid, output code_word, input ready);
  modport sink   (input valid, input code_word, output ready);
endinterface

interface hbd_out_if;
  logic                        valid;
  logic                        ready;
  logic [hbd_pkg::DATA_W-1:0]  data_word;
  logic                        uncorrectable;

  modport source (output valid, output data_word, output uncorrectable, input ready);
  modport sink   (input valid, input data_word, input uncorrectable, output ready);
endinterface

// ===== rtl/hbd_syndrome.sv =====
module hbd_syndrome #(
  parameter int MAX_CODE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [hbd_pkg::CODE_W-1:0]  code_word,
  input  logic [hbd_pkg::LEN_W-1:0]   cfg_len,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [hbd_pkg::CODE_W-1:0]  word_o,
  output hbd_pkg::s1_ctl_t            ctl_o
);

  localparam int LW   = hbd_pkg::LEN_W;
  localparam int SW   = hbd_pkg::SYN_W;
  localparam int SCAN = (MAX_CODE_BITS < hbd_pkg::CODE_W) ? MAX_CODE_BITS : hbd_pkg::CODE_W;

  logic [LW-1:0]               len_eff;
  logic [SW-1:0]               syn_nxt;
  logic                        valid_r;
  logic [hbd_pkg::CODE_W-1:0]  word_r;
  hbd_pkg::s1_ctl_t            ctl_r;

  // saturate length at the build-time maximum
  assign len_eff = ({1'b0, cfg_len} > (LW+1)'(MAX_CODE_BITS)) ? LW'(MAX_CODE_BITS) : cfg_len;

  always_comb begin
    syn_nxt = '0;
    for (int p = 1; p <= SCAN; p++) begin
      if (code_word[p-1] && ({1'b0, len_eff} >= (LW+1)'(p))) syn_nxt = syn_nxt ^ SW'(p);
    end
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      word_r    <= code_word;
      ctl_r.len <= len_eff;
      ctl_r.syn <= syn_nxt;
    end
  end

  assign valid_o = valid_r;
  assign word_o  = word_r;
  assign ctl_o   = ctl_r;

endmodule

// ===== rtl/hbd_correct.sv =====
module hbd_correct #(
  parameter int MAX_CODE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [hbd_pkg::CODE_W-1:0]  word_i,
  input  hbd_pkg::s1_ctl_t            ctl_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [MAX_CODE_BITS-1:0]    word_o,
  output hbd_pkg::s2_ctl_t            ctl_o
);

  localparam int W  = MAX_CODE_BITS;
  localparam int PW = $clog2(W + 1) + 1;  // holds every position number 1..W

  logic [W-1:0]     wide;
  logic [W-1:0]     flip;
  logic             in_range;
  logic             bad_nxt;
  logic             valid_r;
  logic [W-1:0]     word_r;
  hbd_pkg::s2_ctl_t ctl_r;

  assign wide     = W'(word_i);
  assign in_range = (ctl_i.syn <= ctl_i.len);
  assign bad_nxt  = (ctl_i.syn != '0) && !in_range;

  always_comb begin
    for (int i = 0; i < W; i++) begin
      flip[i] = in_range && (PW'(ctl_i.syn) == PW'(i + 1));
    end
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      word_r    <= wide ^ flip;
      ctl_r.len <= ctl_i.len;
      ctl_r.bad <= bad_nxt;
    end
  end

  assign valid_o = valid_r;
  assign word_o  = word_r;
  assign ctl_o   = ctl_r;

`ifndef ASSERT_OFF
  a_single_flip: assert property (@(posedge clk) disable iff (!rst_n)
    valid_i |-> $onehot0(flip))
    else $error("more than one bit selected for correction");

  a_bad_no_flip: assert property (@(posedge clk) disable iff (!rst_n)
    valid_i && bad_nxt |-> flip == '0)
    else $error("correction applied to uncorrectable word");
`endif

endmodule

// ===== rtl/hbd_extract.sv =====
module hbd_extract #(
  parameter int MAX_CODE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [MAX_CODE_BITS-1:0]    word_i,
  input  hbd_pkg::s2_ctl_t            ctl_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [hbd_pkg::DATA_W-1:0]  data_word,
  output logic                        uncorrectable
);

  localparam int LW = hbd_pkg::LEN_W;
  localparam int DW = hbd_pkg::DATA_W;

  logic [DW-1:0] data_nxt;
  logic          valid_r;
  logic [DW-1:0] data_r;
  logic          bad_r;

  for (genvar d = 0; d < DW; d++) begin : g_bit
    localparam int P = hbd_pkg::data_pos(d);
    if (P <= MAX_CODE_BITS) begin : g_live
      assign data_nxt[d] = word_i[P-1] && (ctl_i.len >= LW'(P)) && !ctl_i.bad;
    end else begin : g_none
      assign data_nxt[d] = 1'b0;
    end
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      data_r <= data_nxt;
      bad_r  <= ctl_i.bad;
    end
  end

  assign valid_o       = valid_r;
  assign data_word     = data_r;
  assign uncorrectable = bad_r;

endmodule

// ===== rtl/hamming_block_decoder.sv =====
// Channel  Dir  Beat                           Handshake
// in_ch    in   code_word[31:0]                valid/ready
// out_ch   out  data_word[25:0], uncorrectable valid/ready
// cfg      in   cfg_wdata[5:0] (code_length)   cfg_we, no ready
//
// One beat per clock while out_ch does not stall; stages are syndrome, correct, extract.
// Depth is set by the three register stages; each holds one beat.
// Reset clears all stage valid bits and loads code_length with 7.
// Stall on out_ch freezes the output stage; ready ripples back per stage,
// so an empty stage keeps accepting while later stages hold.
module hamming_block_decoder #(
  parameter int MAX_CODE_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [hbd_pkg::LEN_W-1:0]  cfg_wdata,
  hbd_in_if.sink                     in_ch,
  hbd_out_if.source                  out_ch
);

  // code_length register; the user must write it only while the pipe is empty (not enforced here)
  logic [hbd_pkg::LEN_W-1:0] len_r;

  // stage 1 -> 2
  logic                       s1_valid;
  logic                       s1_ready;
  logic [hbd_pkg::CODE_W-1:0] s1_word;
  hbd_pkg::s1_ctl_t           s1_ctl;

  // stage 2 -> 3
  logic                       s2_valid;
  logic                       s2_ready;
  logic [MAX_CODE_BITS-1:0]   s2_word;
  hbd_pkg::s2_ctl_t           s2_ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= hbd_pkg::LEN_RESET;
    end else if (cfg_we) begin
      len_r <= cfg_wdata;
    end
  end

  // stage 1: saturate length, XOR positions of set bits into syndrome
  hbd_syndrome #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_syn (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (in_ch.valid),
    .ready_o   (in_ch.ready),
    .code_word (in_ch.code_word),
    .cfg_len   (len_r),
    .valid_o   (s1_valid),
    .ready_i   (s1_ready),
    .word_o    (s1_word),
    .ctl_o     (s1_ctl)
  );

  // stage 2: flip the named bit, or flag a syndrome past the length
  hbd_correct #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_cor (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .word_i  (s1_word),
    .ctl_i   (s1_ctl),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .word_o  (s2_word),
    .ctl_o   (s2_ctl)
  );

  // stage 3: pack non-parity positions; this is the output register
  hbd_extract #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_ext (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid_i       (s2_valid),
    .ready_o       (s2_ready),
    .word_i        (s2_word),
    .ctl_i         (s2_ctl),
    .valid_o       (out_ch.valid),
    .ready_i       (out_ch.ready),
    .data_word     (out_ch.data_word),
    .uncorrectable (out_ch.uncorrectable)
  );

`ifndef ASSERT_OFF
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.uncorrectable |-> out_ch.data_word == '0)
    else $error("data nonzero on uncorrectable beat");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (len_r < hbd_pkg::LEN_W'(3)) |-> out_ch.data_word == '0)
    else $error("data bits present with no data positions");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.valid && !s1_valid && !s2_valid && out_ch.ready |=> !out_ch.valid)
    else $error("output beat appeared from empty pipeline");
`endif

endmodule

// ===== verif/hbd_decode_checker.sv =====
// Watches both channels of the decoder, predicts each result beat from the
// accepted codeword and the current code_length, and compares in order.
module hbd_decode_checker #(
  parameter int MAX_CODE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [hbd_pkg::LEN_W-1:0] cfg_wdata,
  hbd_in_if                         in_mon,
  hbd_out_if                        out_mon,
  output int                        outstanding,
  output int                        mismatches,
  output int                        corrected,
  output int                        flagged
);
  timeunit 1ns;
  timeprecision 1ps;

  import hbd_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] data_word;
    logic              uncorrectable;
    logic              fixed;          // single bit repaired, not compared
  } decode_t;

  decode_t          pending_q[$];
  logic [LEN_W-1:0] code_len;
  int               errs    = 0;
  int               n_fixed = 0;
  int               n_bad   = 0;

  function automatic decode_t hamming_decode(input logic [CODE_W-1:0] cw,
                                             input logic [LEN_W-1:0]  len_reg);
    int               n;
    int               syn;
    int               di;
    logic [CODE_W-1:0] w;
    decode_t          r;
    n   = (len_reg > MAX_CODE_BITS) ? MAX_CODE_BITS : int'(len_reg);
    syn = 0;
    r   = '0;
    w   = cw;
    for (int p = 1; p <= n; p++) begin
      if (w[p-1]) syn = syn ^ p;
    end
    if (syn != 0) begin
      if (syn <= n) begin
        w[syn-1] = ~w[syn-1];
        r.fixed  = 1'b1;
      end else begin
        r.uncorrectable = 1'b1;
      end
    end
    if (!r.uncorrectable) begin
      di = 0;
      for (int p = 1; p <= n; p++) begin
        if ((p & (p - 1)) != 0) begin
          if (di < DATA_W) r.data_word[di] = w[p-1];
          di++;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    decode_t want;
    if (!rst_n) begin
      code_len = LEN_RESET;
      pending_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (pending_q.size() == 0) begin
          errs++;
          $error("result beat with nothing outstanding: data_word %h uncorrectable %b",
                 out_mon.data_word, out_mon.uncorrectable);
        end else begin
          want = pending_q.pop_front();
          if (out_mon.data_word !== want.data_word) begin
            errs++;
            $error("data_word: expected %h, actual %h", want.data_word, out_mon.data_word);
          end
          if (out_mon.uncorrectable !== want.uncorrectable) begin
            errs++;
            $error("uncorrectable: expected %b, actual %b",
                   want.uncorrectable, out_mon.uncorrectable);
          end
        end
      end
      // a beat taken on the same edge as a write still sees the old length
      if (in_mon.valid && in_mon.ready) begin
        want = hamming_decode(in_mon.code_word, code_len);
        pending_q.push_back(want);
        if (want.fixed) n_fixed++;
        if (want.uncorrectable) n_bad++;
      end
      if (cfg_we) code_len = cfg_wdata;
    end
    outstanding <= pending_q.size();
    mismatches  <= errs;
    corrected   <= n_fixed;
    flagged     <= n_bad;
  end

endmodule

// ===== verif/tb_hamming_block_decoder.sv =====
// Testbench top: drives codewords and code_length settings into the decoder,
// toggles sender/receiver idling per phase, and gives the verdict.
// All prediction and comparison lives in hbd_decode_checker.
module tb_hamming_block_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import hbd_pkg::*;

  localparam int MAX_BITS     = 32;
  localparam int N_SEGS       = 20;    // random phases
  localparam int SEG_BEATS    = 95;    // codewords per random phase
  localparam int PRESSURE_SEG = 4;     // phase with the long output hold-off
  localparam int HOLD_CYCLES  = 400;   // length of that hold-off
  localparam int DRAIN_CYCLES = 4;     // pipeline is three stages deep
  localparam int QUIET_LIMIT  = 2000;  // cycles without any beat before giving up

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  hbd_in_if  in_ch();
  hbd_out_if out_ch();

  int               outstanding;
  int               mismatches;
  int               corrected;
  int               flagged;

  int               tx_idle_pct  = 0;  // used only by the stimulus process
  int               rx_stall_pct = 0;  // written with NBAs, read by the receiver
  bit               long_hold    = 1'b0;
  logic [LEN_W-1:0] cur_len      = LEN_RESET;
  int               len_writes   = 0;
  int               beats_sent   = 0;
  int               quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hamming_block_decoder #(
    .MAX_CODE_BITS(MAX_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  hbd_decode_checker #(
    .MAX_CODE_BITS(MAX_BITS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .outstanding(outstanding),
    .mismatches (mismatches),
    .corrected  (corrected),
    .flagged    (flagged)
  );

  // Receiver side. Random backpressure per phase; the first time long_hold is
  // seen it drops ready for HOLD_CYCLES straight so the three stages fill and
  // the input side has to stall.
  initial begin : rx_drive
    int hold_left;
    bit hold_taken;
    hold_left    = 0;
    hold_taken   = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog: any stretch this long with no beat on either channel is a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Effective number of positions in use; register values above the width
  // of the codeword saturate.
  function automatic int bits_in_use(input logic [LEN_W-1:0] len);
    return (len > MAX_BITS) ? MAX_BITS : int'(len);
  endfunction

  // Builds a proper codeword over positions 1..n (random data, parity set so
  // the syndrome is zero), then flips 'flips' random positions inside the
  // length. With junk set, random bits land above the length as well.
  function automatic logic [CODE_W-1:0] make_word(input int n, input int flips,
                                                  input bit junk);
    logic [CODE_W-1:0] w;
    logic [CODE_W-1:0] noise;
    int                syn;
    int                p;
    w     = $urandom();
    noise = $urandom();
    syn   = 0;
    for (int q = 1; q <= CODE_W; q++) begin
      if (q <= n) noise[q-1] = 1'b0;
      if (q > n || (q & (q - 1)) == 0) w[q-1] = 1'b0;
      else if (w[q-1]) syn = syn ^ q;
    end
    // every set syndrome bit k has 2**k <= n, so its parity position exists
    for (int k = 0; k < 6; k++) begin
      if ((syn >> k) & 1) w[(1 << k) - 1] = 1'b1;
    end
    if (n > 0) begin
      repeat (flips) begin
        p      = $urandom_range(1, n);
        w[p-1] = ~w[p-1];
      end
    end
    if (junk) w = w | noise;
    return w;
  endfunction

  // Offers one codeword, with random idle cycles ahead of it; returns at the
  // edge where the beat is accepted, leaving valid high for a back-to-back beat.
  task automatic send_beat(input logic [CODE_W-1:0] w);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.code_word <= w;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  // Stops offering and waits until every predicted result has been checked.
  // The first edge lets the checker count a beat accepted on this very edge.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // code_length is only rewritten with the pipeline empty.
  task automatic set_length(input logic [LEN_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_len  = v;
    len_writes++;
  endtask

  initial begin : stimulus
    logic [CODE_W-1:0] w;
    logic [LEN_W-1:0]  v;
    int                n;
    int                pick;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.code_word = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: reset length of 7 (a 7,4 code) ----
    send_beat('0);
    send_beat('1);                 // all ones in use, syndrome zero
    send_beat(32'h0000_007F);
    send_beat(32'hFFFF_FF80);      // everything above the length is ignored
    send_beat(make_word(7, 0, 1'b0));
    for (int p = 1; p <= 7; p++) begin
      w      = make_word(7, 0, 1'b0);
      w[p-1] = ~w[p-1];            // single error at each position
      send_beat(w);
    end

    // ---- directed: full 32-bit length ----
    set_length(6'd32);
    send_beat('1);                 // syndrome 32 names the top bit
    send_beat(make_word(32, 1, 1'b0));
    send_beat(make_word(32, 2, 1'b0));

    // ---- directed: degenerate short lengths, no data positions ----
    set_length(6'd0);
    send_beat('1);
    set_length(6'd1);
    send_beat('1);
    set_length(6'd2);
    send_beat('1);                 // syndrome 3 is past the length

    // ---- directed: register above the codeword width saturates ----
    set_length(6'd63);
    send_beat('1);
    send_beat(make_word(32, 1, 1'b0));

    // ---- directed: shortest real code ----
    set_length(6'd3);
    send_beat(32'h0000_0005);      // syndrome 2, parity bit repaired
    send_beat(32'hFFFF_FFF8);

    // ---- random phases ----
    for (int seg = 0; seg < N_SEGS; seg++) begin
      // first phases sweep the edges of the register, later ones mostly
      // legal lengths with an occasional out-of-range value
      case (seg)
        0: v = 6'd32;
        1: v = 6'd3;
        2: v = 6'd63;
        3: v = 6'd0;
        4: v = 6'd31;
        5: v = 6'd33;
        6: v = 6'd2;
        7: v = 6'd1;
        default: v = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(0, 63))
                                                 : LEN_W'($urandom_range(3, 32));
      endcase
      set_length(v);

      case (seg % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 70; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 70; end
        default: begin tx_idle_pct = 7; rx_stall_pct <= 7; end
      endcase
      if (seg == PRESSURE_SEG) long_hold <= 1'b1;

      n = bits_in_use(cur_len);
      for (int k = 0; k < SEG_BEATS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 20)      w = make_word(n, 0, 1'($urandom_range(0, 1)));
        else if (pick < 60) w = make_word(n, 1, 1'($urandom_range(0, 1)));
        else if (pick < 80) w = make_word(n, 2, 1'($urandom_range(0, 1)));
        else                w = $urandom();
        send_beat(w);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Decoded %0d codewords across %0d code_length writes: %0d repaired, %0d uncorrectable.",
             beats_sent, len_writes, corrected, flagged);
    $display("Phases ran with no idling, sender gaps, receiver stalls, both, and a %0d-cycle hold.",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
